### sv/plid_pkg.sv
// Shared codes, types and defaults for the positional list block.
package plid_pkg;

    // Default list capacity and dump window size
    localparam int DEPTH_DEF = 128;
    localparam int DUMP_MAX  = 64;

    // Command modes
    localparam logic [2:0] MODE_CREATE  = 3'd0;
    localparam logic [2:0] MODE_DESTROY = 3'd1;
    localparam logic [2:0] MODE_INSERT  = 3'd2;
    localparam logic [2:0] MODE_DELETE  = 3'd3;
    localparam logic [2:0] MODE_DUMP    = 3'd4;

    // Result status codes
    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_NOT_CREATED = 3'd1;
    localparam logic [2:0] STAT_EXISTS      = 3'd2;
    localparam logic [2:0] STAT_EMPTY       = 3'd3;
    localparam logic [2:0] STAT_FULL        = 3'd4;
    localparam logic [2:0] STAT_BAD_POS     = 3'd5;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic signed [31:0] value;
    } cell_ctl_t;

    // Controller states
    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_DUMP = 2'b10
    } fsm_t;

endpackage

### sv/plid_cell.sv
// One storage cell of the list chain; shifts with its neighbors on command.
module plid_cell #(
    parameter int DEPTH = plid_pkg::DEPTH_DEF,
    parameter int INDEX = 0
) (
    input  logic                         aclk,
    input  plid_pkg::cell_ctl_t          ctl,
    input  logic [$clog2(DEPTH)-1:0]     pos_idx,    // 0-based target slot
    input  logic signed [31:0]           left_data,  // cell INDEX-1
    input  logic signed [31:0]           right_data, // cell INDEX+1 (ring)
    output logic signed [31:0]           data
);
    import plid_pkg::*;

    localparam int IDXW = $clog2(DEPTH);
    localparam logic [IDXW-1:0] MY_IDX = IDXW'(INDEX);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    // Insert opens a gap at the target, delete closes it, rotate walks left
    always_comb begin
        data_next = data_reg;
        case (ctl.op)
            OP_INSERT: begin
                if (MY_IDX == pos_idx) begin
                    data_next = ctl.value;
                end else if (MY_IDX > pos_idx) begin
                    data_next = left_data;
                end
            end
            OP_DELETE: begin
                if (MY_IDX >= pos_idx) begin
                    data_next = right_data;
                end
            end
            OP_ROTATE: data_next = right_data;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### sv/positional_list_insert_delete.sv
// Top level: ordered list of signed values kept in a chain of shifting cells.
//
// Usage:
//   Input stream (s_*): one beat per command. tdata holds mode, position and
//   value. Insert and delete shift the cells from the target on in the accept
//   cycle; all but an accepted dump give one result beat with tlast high.
//   Output stream (m_*): tdata holds status, element, element_index and
//   length_now; tlast marks the final result beat of a command.
//   Result timing: a single result beat is valid in the cycle after the command
//   beat; dump beats follow in element order through the output register.
//   Throughput: one command per cycle for non-dump commands while the output
//   is taken. A dump rotates the ring of DEPTH cells once, one cell per cycle
//   unless an output stall holds it, emitting the head cell while it lies
//   inside the window of up to 64 elements, so after the dump beat the input
//   stays closed until the rotation ends.
//   Reset (aresetn low, synchronous): list absent, length zero, no result
//   pending. Element storage is not cleared.
//   Stall: with m_tready low the result beat holds in the output register;
//   s_tready drops and the dump rotation pauses before emitting its next cell.
module positional_list_insert_delete #(
    parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mode[2:0], position[10:3], value[42:11], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[2:0], element[34:3],
                                   // element_index[42:35], length_now[50:43], zero
    output logic        m_tlast
);
    import plid_pkg::*;

    localparam int IDXW = $clog2(DEPTH);
    localparam int LENW = $clog2(DEPTH + 1);
    localparam int CW   = ((LENW > 8) ? LENW : 8) + 1;
    localparam logic [CW-1:0] C_DEPTH  = CW'(DEPTH);
    localparam logic [CW-1:0] C_WINDOW = CW'(DUMP_MAX - 1);

    // Input fields
    logic [2:0]         in_mode;
    logic [7:0]         in_pos;
    logic signed [31:0] in_value;
    assign in_mode  = s_tdata[2:0];
    assign in_pos   = s_tdata[10:3];
    assign in_value = s_tdata[42:11];

    // Control state
    fsm_t            state_reg, state_next;
    logic [LENW-1:0] length_reg, length_next;
    logic            created_reg, created_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   start_reg, start_next;
    logic [CW-1:0]   end_reg, end_next;
    logic            m_valid_reg, m_valid_next;

    // Output payload
    logic [2:0]         out_status_reg, out_status_next;
    logic signed [31:0] out_elem_reg, out_elem_next;
    logic [7:0]         out_idx_reg, out_idx_next;
    logic [7:0]         out_len_reg, out_len_next;
    logic               out_last_reg, out_last_next;

    // Chain interface
    cell_ctl_t          ctl;
    logic [IDXW-1:0]    pos_idx;
    logic signed [31:0] cell_data [DEPTH];

    logic          s_fire;
    logic [CW-1:0] len_ext, pos_ext, pos_m1, dump_start, dump_span;
    logic          emit, adv;

    assign s_tready = (state_reg == FSM_IDLE) && (!m_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;

    assign len_ext    = CW'(length_reg);
    assign pos_ext    = CW'(in_pos);
    assign pos_m1     = pos_ext - CW'(1);
    assign pos_idx    = pos_m1[IDXW-1:0];
    assign dump_start = (in_pos == 8'd0) ? CW'(1) : pos_ext;
    assign dump_span  = len_ext - dump_start;

    // Dump window check on the cell currently at the head of the ring
    assign emit = (cnt_reg >= start_reg) && (cnt_reg <= end_reg);
    assign adv  = !emit || !m_valid_reg || m_tready;

    // Command decode and dump sequencing
    always_comb begin
        state_next      = state_reg;
        length_next     = length_reg;
        created_next    = created_reg;
        cnt_next        = cnt_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_elem_next   = out_elem_reg;
        out_idx_next    = out_idx_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        ctl.op          = OP_HOLD;
        ctl.value       = in_value;

        case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    out_status_next = STAT_OK;
                    case (in_mode)
                        MODE_CREATE: begin
                            if (created_reg && length_reg != '0) begin
                                out_status_next = STAT_EXISTS;
                            end else begin
                                created_next = 1'b1;
                                length_next  = '0;
                            end
                        end
                        MODE_DESTROY: begin
                            if (!created_reg) begin
                                out_status_next = STAT_NOT_CREATED;
                            end else begin
                                created_next = 1'b0;
                                length_next  = '0;
                            end
                        end
                        MODE_INSERT: begin
                            if (!created_reg) begin
                                out_status_next = STAT_NOT_CREATED;
                            end else if (len_ext == C_DEPTH) begin
                                out_status_next = STAT_FULL;
                            end else if (in_pos == 8'd0 || pos_ext > len_ext + CW'(1)) begin
                                out_status_next = STAT_BAD_POS;
                            end else begin
                                ctl.op      = OP_INSERT;
                                length_next = length_reg + LENW'(1);
                            end
                        end
                        MODE_DELETE: begin
                            if (!created_reg) begin
                                out_status_next = STAT_NOT_CREATED;
                            end else if (length_reg == '0) begin
                                out_status_next = STAT_EMPTY;
                            end else if (in_pos == 8'd0 || pos_ext > len_ext) begin
                                out_status_next = STAT_BAD_POS;
                            end else begin
                                ctl.op      = OP_DELETE;
                                length_next = length_reg - LENW'(1);
                            end
                        end
                        MODE_DUMP: begin
                            if (!created_reg) begin
                                out_status_next = STAT_NOT_CREATED;
                            end else if (length_reg == '0) begin
                                out_status_next = STAT_EMPTY;
                            end else if (dump_start > len_ext) begin
                                out_status_next = STAT_BAD_POS;
                            end else begin
                                state_next = FSM_DUMP;
                                cnt_next   = CW'(1);
                                start_next = dump_start;
                                end_next   = (dump_span >= C_WINDOW) ?
                                             dump_start + C_WINDOW : len_ext;
                            end
                        end
                        default: out_status_next = STAT_OK;
                    endcase

                    // Single-beat result unless a dump window was opened
                    if (state_next == FSM_IDLE) begin
                        m_valid_next  = 1'b1;
                        out_elem_next = '0;
                        out_idx_next  = '0;
                        out_len_next  = 8'(CW'(length_next));
                        out_last_next = 1'b1;
                    end
                end
            end
            FSM_DUMP: begin
                if (adv) begin
                    ctl.op   = OP_ROTATE;
                    cnt_next = cnt_reg + CW'(1);
                    if (emit) begin
                        m_valid_next    = 1'b1;
                        out_status_next = STAT_OK;
                        out_elem_next   = cell_data[0];
                        out_idx_next    = cnt_reg[7:0];
                        out_len_next    = 8'(len_ext);
                        out_last_next   = (cnt_reg == end_reg);
                    end
                    if (cnt_reg == C_DEPTH) begin
                        state_next = FSM_IDLE;
                    end
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            length_reg  <= '0;
            created_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            length_reg  <= length_next;
            created_reg <= created_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_elem_reg   <= out_elem_next;
        out_idx_reg    <= out_idx_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
    end

    // Ring of storage cells; the last cell's right neighbor is cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        plid_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .pos_idx    (pos_idx),
            .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == DEPTH - 1) ? 0 : i + 1]),
            .data       (cell_data[i])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_len_reg, out_idx_reg, out_elem_reg, out_status_reg};

endmodule

### dv/list_result_checker.sv
// Checker for the positional list: predicts every result beat and compares it.
`timescale 1ns / 1ps

module list_result_checker #(
    parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatch_total,
    output int          backlog,
    output int          cmd_total,
    output int          beat_total,
    output int          dump_total,
    output int          full_total
);
    import plid_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] element;
        logic [7:0]  index;
        logic [7:0]  len;
        logic        last;
    } result_beat_t;

    // Predicted list contents
    logic [31:0]  slots [DEPTH];
    int           list_len;
    bit           list_made;
    result_beat_t expected_q[$];

    int n_mismatch;
    int n_cmd;
    int n_beat;
    int n_dump;
    int n_full;

    task automatic queue_result(input logic [2:0] st, input logic [31:0] elem, input int idx,
                                input logic last);
        result_beat_t b;
        b.status  = st;
        b.element = elem;
        b.index   = idx[7:0];
        b.len     = list_len[7:0];
        b.last    = last;
        expected_q.push_back(b);
    endtask

    // Apply one command to the predicted list and queue the beats it causes
    task automatic run_command(input logic [2:0] mode, input logic [7:0] pos_bits,
                               input logic [31:0] val);
        logic [2:0] st;
        int         pos;
        int         first;
        int         stop;
        int         i;
        st  = STAT_OK;
        pos = int'(pos_bits);
        case (mode)
            MODE_CREATE: begin
                if (list_made && list_len > 0) begin
                    st = STAT_EXISTS;
                end else begin
                    list_made = 1'b1;
                    list_len  = 0;
                end
            end
            MODE_DESTROY: begin
                if (!list_made) begin
                    st = STAT_NOT_CREATED;
                end else begin
                    list_made = 1'b0;
                    list_len  = 0;
                end
            end
            MODE_INSERT: begin
                if (!list_made) begin
                    st = STAT_NOT_CREATED;
                end else if (list_len >= DEPTH) begin
                    st = STAT_FULL;
                    n_full++;
                end else if (pos < 1 || pos > list_len + 1) begin
                    st = STAT_BAD_POS;
                end else begin
                    for (i = list_len; i >= pos; i--) slots[i] = slots[i-1];
                    slots[pos-1] = val;
                    list_len++;
                end
            end
            MODE_DELETE: begin
                if (!list_made) begin
                    st = STAT_NOT_CREATED;
                end else if (list_len == 0) begin
                    st = STAT_EMPTY;
                end else if (pos < 1 || pos > list_len) begin
                    st = STAT_BAD_POS;
                end else begin
                    for (i = pos; i < list_len; i++) slots[i-1] = slots[i];
                    list_len--;
                end
            end
            MODE_DUMP: begin
                if (!list_made) begin
                    st = STAT_NOT_CREATED;
                end else if (list_len == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    first = (pos < 1) ? 1 : pos;
                    if (first > list_len) begin
                        st = STAT_BAD_POS;
                    end else begin
                        // window of at most DUMP_MAX elements from the start index
                        stop = list_len;
                        if (stop - first + 1 > DUMP_MAX) stop = first + DUMP_MAX - 1;
                        for (i = first; i <= stop; i++)
                            queue_result(STAT_OK, slots[i-1], i, i == stop);
                        n_dump++;
                        return;
                    end
                end
            end
            default: ;  // spare modes leave the list alone
        endcase
        queue_result(st, '0, 0, 1'b1);
    endtask

    // Compare one received beat with the oldest prediction
    task automatic check_result(input result_beat_t got);
        result_beat_t want;
        if (expected_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("[%0t] beat %0d arrived with nothing predicted: status %0d element %0d",
                         $time, n_beat, got.status, $signed(got.element));
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status || got.element !== want.element ||
            got.index !== want.index || got.len !== want.len || got.last !== want.last) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display({"[%0t] beat %0d: status %0d/%0d element %0d/%0d index %0d/%0d ",
                          "length %0d/%0d last %0d/%0d (expected/actual)"},
                         $time, n_beat, want.status, got.status,
                         $signed(want.element), $signed(got.element),
                         want.index, got.index, want.len, got.len, want.last, got.last);
        end
    endtask

    // Watch both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            list_made  = 1'b0;
            list_len   = 0;
            expected_q.delete();
            n_mismatch = 0;
            n_cmd      = 0;
            n_beat     = 0;
            n_dump     = 0;
            n_full     = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                n_cmd++;
                run_command(s_tdata[2:0], s_tdata[10:3], s_tdata[42:11]);
            end
            if (m_tvalid && m_tready) begin
                check_result({m_tdata[2:0], m_tdata[34:3], m_tdata[42:35], m_tdata[50:43],
                              m_tlast});
                n_beat++;
            end
        end
        mismatch_total <= n_mismatch;
        backlog        <= expected_q.size();
        cmd_total      <= n_cmd;
        beat_total     <= n_beat;
        dump_total     <= n_dump;
        full_total     <= n_full;
    end

endmodule

### dv/positional_list_insert_delete_test.sv
// Testbench top for the positional list: stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module positional_list_insert_delete_test;
    import plid_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int CHOKE_CYCLES = 400;
    // slowest legal command: long sender gap, full ring rotation, 64 beats each
    // behind a long receiver stall; the timeout covers ~530 such commands 3x over
    localparam int TIMEOUT_CYCLES = 5_000_000;

    // spare mode codes that the block must answer with a plain ok
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // segment kinds of the random part
    localparam int SEG_GROW   = 0;
    localparam int SEG_SHRINK = 1;
    localparam int SEG_MIXED  = 2;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // mode[2:0], position[10:3], value[42:11], zero
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // status[2:0], element[34:3], element_index[42:35],
                            // length_now[50:43], zero
    logic        m_tlast;

    int mismatch_total;
    int backlog;
    int cmd_total;
    int beat_total;
    int dump_total;
    int full_total;

    // shadow of length and created flag, only to aim positions
    int sh_len;
    bit sh_made;
    int sh_peak;

    bit tx_steady;
    bit rx_steady;
    int choke_tag;
    int choke_seen;
    int rx_hold;
    int rx_pick;
    int cycles;

    positional_list_insert_delete #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    list_result_checker #(
        .DEPTH(LIST_DEPTH)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_total (mismatch_total),
        .backlog        (backlog),
        .cmd_total      (cmd_total),
        .beat_total     (beat_total),
        .dump_total     (dump_total),
        .full_total     (full_total)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still pending", cycles, backlog);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random stalls, a requested long hold-off, or steady acceptance
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (choke_tag != choke_seen) begin
            choke_seen = choke_tag;
            rx_hold    = CHOKE_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 70) begin
                m_tready <= 1'b1;
            end else if (rx_pick < 95) begin
                rx_hold = $urandom_range(1, 3) - 1;
                m_tready <= 1'b0;
            end else begin
                rx_hold = $urandom_range(10, 40) - 1;
                m_tready <= 1'b0;
            end
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Offer one command beat and wait until it is taken
    task automatic issue(input logic [2:0] mode, input int pos, input logic [31:0] val);
        int gap;
        gap = tx_steady ? 0 : sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {5'd0, val, pos[7:0], mode};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        // keep the shadow in step for position aiming
        case (mode)
            MODE_CREATE:  if (!(sh_made && sh_len > 0)) begin sh_made = 1'b1; sh_len = 0; end
            MODE_DESTROY: if (sh_made) begin sh_made = 1'b0; sh_len = 0; end
            MODE_INSERT:  if (sh_made && sh_len < LIST_DEPTH && pos >= 1 && pos <= sh_len + 1)
                              sh_len++;
            MODE_DELETE:  if (sh_made && pos >= 1 && pos <= sh_len) sh_len--;
            default: ;
        endcase
        if (sh_len > sh_peak) sh_peak = sh_len;
    endtask

    // Sender pauses until every predicted beat has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (backlog != 0);
    endtask

    // One random command, weighted by segment kind
    task automatic random_command(input int kind);
        int          r;
        int          q;
        int          ins_w;
        int          del_w;
        int          pos;
        logic [2:0]  mode;
        logic [31:0] val;
        r   = $urandom_range(0, 99);
        q   = $urandom_range(0, 9);
        val = pick_value();
        case (kind)
            SEG_GROW:   begin ins_w = 80; del_w = 5;  end
            SEG_SHRINK: begin ins_w = 20; del_w = 60; end
            default:    begin ins_w = 45; del_w = 35; end
        endcase
        if ((!sh_made && r < 85) || (sh_made && r >= 3 + ins_w + del_w + 11 && r < 98)) begin
            mode = MODE_CREATE;
            pos  = $urandom_range(0, 255);
        end else if (r < 3 || !sh_made) begin
            // noise: any mode, any position
            mode = 3'($urandom_range(0, 7));
            pos  = $urandom_range(0, 255);
            val  = $urandom;
        end else if (r < 3 + ins_w) begin
            mode = MODE_INSERT;
            if (q == 0)      pos = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(sh_len + 2, 255);
            else if (q < 3)  pos = 1;
            else if (q < 5)  pos = sh_len + 1;
            else             pos = $urandom_range(1, sh_len + 1);
        end else if (r < 3 + ins_w + del_w) begin
            mode = MODE_DELETE;
            if (sh_len == 0)   pos = $urandom_range(0, 3);
            else if (q == 0)   pos = ($urandom_range(0, 1) == 0) ? 0
                                                                 : $urandom_range(sh_len + 1, 255);
            else if (q < 3)    pos = 1;
            else if (q < 5)    pos = sh_len;
            else               pos = $urandom_range(1, sh_len);
        end else if (r < 3 + ins_w + del_w + 11) begin
            mode = MODE_DUMP;
            if (q < 4)                     pos = $urandom_range(0, 1);
            else if (q < 9 && sh_len > 0)  pos = $urandom_range(1, sh_len);
            else                           pos = $urandom_range(sh_len + 1, 255);
        end else begin
            mode = MODE_DESTROY;
            pos  = $urandom_range(0, 255);
        end
        issue(mode, pos, val);
    endtask

    // Stimulus
    initial begin
        int seg;
        int n;
        int seg_len;
        int seg_kind;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        aresetn  <= 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: insert, delete, dump and destroy on an absent list
        issue(MODE_INSERT,  1, 32'd5);
        issue(MODE_DELETE,  1, 32'd0);
        issue(MODE_DUMP,    0, 32'd0);
        issue(MODE_DESTROY, 0, 32'd0);
        // create, then create again on the empty list
        issue(MODE_CREATE,  0, 32'd0);
        issue(MODE_CREATE,  0, 32'd0);
        // empty list errors and bad insert positions
        issue(MODE_DUMP,    1, 32'd0);
        issue(MODE_DELETE,  1, 32'd0);
        issue(MODE_INSERT,  0, 32'd1);
        issue(MODE_INSERT,  2, 32'd1);
        // build a five element list with extreme values, inserts at head, tail, middle
        issue(MODE_INSERT,  1, 32'h8000_0000);
        issue(MODE_INSERT,  2, 32'h7FFF_FFFF);
        issue(MODE_INSERT,  1, 32'hFFFF_FFFF);
        issue(MODE_INSERT,  4, 32'd0);
        issue(MODE_INSERT,  2, 32'd100);
        // create on a populated list, bad delete positions
        issue(MODE_CREATE,  0, 32'd0);
        issue(MODE_DELETE,  0, 32'd0);
        issue(MODE_DELETE,  6, 32'd0);
        issue(MODE_DELETE,  255, 32'd0);
        // whole dump, windowed dump, dump start beyond the end
        issue(MODE_DUMP,    0, 32'd0);
        issue(MODE_DUMP,    3, 32'd0);
        issue(MODE_DUMP,    6, 32'd0);
        issue(MODE_DUMP,    255, 32'hFFFF_FFFF);
        // delete tail and head, spare modes, destroy
        issue(MODE_DELETE,  5, 32'd0);
        issue(MODE_DELETE,  1, 32'd0);
        issue(MODE_SPARE_LO, 255, 32'hFFFF_FFFF);
        issue(MODE_SPARE_HI, 0, 32'd0);
        issue(MODE_DESTROY, 0, 32'd0);
        drain();

        // Random: grow to full, shrink, grow again, then a mixed stretch
        for (seg = 0; seg < 4; seg++) begin
            case (seg)
                0:       begin seg_len = 200; seg_kind = SEG_GROW;   end
                1:       begin seg_len = 100; seg_kind = SEG_SHRINK; end
                2:       begin seg_len = 150; seg_kind = SEG_GROW;   end
                default: begin seg_len = 50;  seg_kind = SEG_MIXED;  end
            endcase
            for (n = 0; n < seg_len; n++) begin
                // long receiver hold-off while the sender keeps offering
                if (seg == 1 && n == 0) begin
                    choke_tag <= choke_tag + 1;
                    tx_steady = 1'b1;
                end
                // a stretch with no idling on either side
                if (seg == 2 && n == 0) begin
                    rx_steady <= 1'b1;
                    tx_steady = 1'b1;
                end
                if ((seg == 1 && n == 40) || (seg == 2 && n == 60)) begin
                    rx_steady <= 1'b0;
                    tx_steady = 1'b0;
                end
                random_command(seg_kind);
            end
            drain();
        end

        // let any ring rotation finish and catch stray beats
        repeat (LIST_DEPTH + 16) @(posedge aclk);

        $display("covered %0d commands, %0d result beats, %0d dumps, %0d inserts on a full list",
                 cmd_total, beat_total, dump_total, full_total);
        $display("peak list length %0d of %0d, one %0d-cycle receiver hold-off",
                 sh_peak, LIST_DEPTH, CHOKE_CYCLES);
        if (mismatch_total == 0 && backlog == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatching beats, %0d results never arrived", mismatch_total, backlog);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
